// ===== sv/mwo_pkg.sv =====
// Shared types, constants and codes for the mecanum wheel odometry unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package mwo_pkg;

    // Fixed field widths
    localparam int POSE_W      = 48;
    localparam int CFG_W       = 32;
    localparam int COEF_W      = 32;
    localparam int RATE_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int INC_LIM_BIT = 60;              // increments clip at +-2^60
    localparam int INC_W       = INC_LIM_BIT + 2; // signed increment width
    localparam int SUM_W       = 64;              // signed wheel combination
    localparam int MAG_W       = SUM_W - 1;       // magnitude of a combination
    localparam int PROD_W      = 64;              // shared multiplier product
    localparam int NUM_WHEELS  = 4;
    localparam int NUM_AXES    = 3;

    typedef logic signed [POSE_W-1:0] t_pose;
    typedef logic        [POSE_W-1:0] t_pose_mag;
    typedef logic signed [INC_W-1:0]  t_inc;
    typedef logic        [COEF_W-1:0] t_coef;
    typedef logic        [RATE_W-1:0] t_rate;
    typedef logic        [1:0]        t_axis;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAD_PER_TICK = 2'd0,
        CFG_LIN_COEFF    = 2'd1,
        CFG_ROT_COEFF    = 2'd2,
        CFG_RATE_HZ      = 2'd3
    } t_cfg_index;

    // Configuration reset values
    localparam t_coef RAD_PER_TICK_RST = 32'd3373259;
    localparam t_coef LIN_COEFF_RST    = 32'd94906266;
    localparam t_coef ROT_COEFF_RST    = 32'd344148042;
    localparam t_rate RATE_HZ_RST      = 16'd50;

    // Axis codes
    localparam t_axis AX_X       = 2'd0;
    localparam t_axis AX_Y       = 2'd1;
    localparam t_axis AX_HEADING = 2'd2;

    // Saturation magnitudes of the signed pose range
    localparam t_pose_mag POSE_POS_MAG = {1'b0, {(POSE_W-1){1'b1}}};
    localparam t_pose_mag POSE_NEG_MAG = {1'b1, {(POSE_W-1){1'b0}}};

    // Strobes from the sequencer to every wheel lane
    typedef struct packed {
        logic sample;
        logic mult;
        logic accum;
        logic clear;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_START,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MG_IDLE,
        MG_MAG,
        MG_LO,
        MG_HI,
        MG_ADD,
        MG_FIN,
        MG_DRAIN1,
        MG_DRAIN2
    } t_merge_state;

endpackage

`default_nettype wire

// ===== sv/mwo_lane.sv =====
// One wheel lane: wrapped count difference, angle increment and saturating
// wheel angle accumulator. Depends on mwo_pkg.
`default_nettype none

module mwo_lane
    import mwo_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int ANGLE_BITS = 56
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_lane_ctl                    i_ctl,
    input  wire logic                         i_first_sample,
    input  wire logic [COUNT_BITS-1:0]        i_count,
    input  wire t_coef                        i_rad_per_tick,
    output t_inc                              o_inc,
    output logic signed [ANGLE_BITS-1:0]      o_angle
);

    localparam int LPROD_W = COUNT_BITS + COEF_W;
    localparam int ACC_W   = ((ANGLE_BITS > INC_W) ? ANGLE_BITS : INC_W) + 1;

    logic [COUNT_BITS-1:0]          r_prev;
    logic [COUNT_BITS-1:0]          w_base;
    logic [COUNT_BITS-1:0]          w_diff;
    logic                           r_neg;
    logic [COUNT_BITS-1:0]          r_dmag;
    logic [LPROD_W-1:0]             r_prod;
    logic [PROD_W-1:0]              w_prod_ext;
    logic                           w_over;
    logic [INC_LIM_BIT:0]           w_mag;
    t_inc                           w_inc;
    t_inc                           r_inc;
    logic signed [ACC_W-1:0]        w_mag_ext;
    logic signed [ACC_W-1:0]        w_angle_ext;
    logic signed [ACC_W-1:0]        w_sum;
    logic [ACC_W-ANGLE_BITS:0]      w_top;
    logic signed [ANGLE_BITS-1:0]   w_angle_sat;
    logic signed [ANGLE_BITS-1:0]   r_angle;

    // Wrapped difference; the first sample compares against itself
    always_comb begin
        w_base = i_first_sample ? i_count : r_prev;
        w_diff = i_count - w_base;
    end

    // Clip the increment magnitude and apply it to the angle
    always_comb begin
        w_prod_ext  = PROD_W'(r_prod);
        w_over      = (w_prod_ext[PROD_W-1:INC_LIM_BIT+1] != '0) ||
                      (w_prod_ext[INC_LIM_BIT] && (w_prod_ext[INC_LIM_BIT-1:0] != '0));
        w_mag       = w_over ? {1'b1, {INC_LIM_BIT{1'b0}}} : w_prod_ext[INC_LIM_BIT:0];
        w_inc       = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        w_mag_ext   = ACC_W'($signed({1'b0, w_mag}));
        w_angle_ext = ACC_W'(r_angle);
        w_sum       = r_neg ? (w_angle_ext - w_mag_ext) : (w_angle_ext + w_mag_ext);
        w_top       = w_sum[ACC_W-1:ANGLE_BITS-1];
        if ((&w_top) || !(|w_top)) begin
            w_angle_sat = w_sum[ANGLE_BITS-1:0];
        end else if (w_sum[ACC_W-1]) begin
            w_angle_sat = {1'b1, {(ANGLE_BITS-1){1'b0}}};
        end else begin
            w_angle_sat = {1'b0, {(ANGLE_BITS-1){1'b1}}};
        end
    end

    // Lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_angle <= '0;
        end else begin
            if (i_ctl.sample) begin
                r_prev <= i_count;
            end
            if (i_ctl.clear) begin
                r_angle <= '0;
            end else if (i_ctl.accum) begin
                r_angle <= w_angle_sat;
            end
        end
    end

    // Lane datapath: sign and magnitude, scale, hold increment
    always_ff @(posedge i_clk) begin
        if (i_ctl.sample) begin
            r_neg  <= w_diff[COUNT_BITS-1];
            r_dmag <= w_diff[COUNT_BITS-1] ? -w_diff : w_diff;
        end
        if (i_ctl.mult) begin
            r_prod <= LPROD_W'(r_dmag * i_rad_per_tick);
        end
        if (i_ctl.accum) begin
            r_inc <= w_inc;
        end
    end

    assign o_inc   = r_inc;
    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ===== sv/mwo_merge.sv =====
// Merging stage: combines the four wheel increments into pose deltas
// through one shared 32x32 multiplier, and into rates through a separate rate multiply. Depends on mwo_pkg.
`default_nettype none

module mwo_merge
    import mwo_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_inc   i_inc [NUM_WHEELS],
    input  wire t_coef  i_lin_coeff,
    input  wire t_coef  i_rot_coeff,
    input  wire t_rate  i_rate_hz,
    output t_pose       o_pose [NUM_AXES],
    output t_pose       o_rate [NUM_AXES],
    output logic        o_done
);

    t_merge_state               r_state;
    t_merge_state               n_state;
    t_axis                      r_axis;
    t_axis                      n_axis;

    logic signed [SUM_W-1:0]    w_ext [NUM_WHEELS];
    logic signed [SUM_W-1:0]    r_sum [NUM_AXES];
    logic [MAG_W-1:0]           r_mag [NUM_AXES];
    logic                       r_sgn [NUM_AXES];

    logic [COEF_W-1:0]          w_opnd;
    t_coef                      w_coef;
    logic [PROD_W-1:0]          w_mul;
    logic [PROD_W-1:0]          r_prod;
    logic [PROD_W-1:0]          r_plo;
    logic [PROD_W-1:0]          r_q;
    logic                       r_fnz;
    logic [PROD_W:0]            w_qr;
    t_pose_mag                  w_lim;
    t_pose_mag                  w_smag;

    t_pose_mag                  r_rmag;
    logic                       r_rsgn;
    t_axis                      r_rax;
    logic                       r_rv1;
    logic [PROD_W-1:0]          r_rprod;
    logic                       r_rsgn2;
    t_axis                      r_rax2;
    logic                       r_rv2;
    t_pose_mag                  w_rlim;
    t_pose_mag                  w_rmag;

    t_pose                      r_res  [NUM_AXES];
    t_pose                      r_rate [NUM_AXES];
    logic                       r_done;

    // Sequence the axes through the shared multiplier
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            MG_IDLE: begin
                if (i_start) begin
                    n_state = MG_MAG;
                end
            end
            MG_MAG: begin
                n_axis  = AX_X;
                n_state = MG_LO;
            end
            MG_LO:  n_state = MG_HI;
            MG_HI:  n_state = MG_ADD;
            MG_ADD: n_state = MG_FIN;
            MG_FIN: begin
                if (r_axis == AX_HEADING) begin
                    n_state = MG_DRAIN1;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = MG_LO;
                end
            end
            MG_DRAIN1: n_state = MG_DRAIN2;
            MG_DRAIN2: n_state = MG_IDLE;
            default:   n_state = MG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MG_IDLE;
            r_axis  <= AX_X;
            r_rv1   <= 1'b0;
            r_rv2   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_rv1   <= (r_state == MG_FIN);
            r_rv2   <= r_rv1;
            r_done  <= (r_state == MG_DRAIN2);
        end
    end

    // Wheel combinations, operand pick and the shared multiply
    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            w_ext[k] = SUM_W'(i_inc[k]);
        end
        w_opnd = (r_state == MG_LO) ? r_mag[r_axis][COEF_W-1:0]
                                    : {1'b0, r_mag[r_axis][MAG_W-1:COEF_W]};
        w_coef = (r_axis == AX_HEADING) ? i_rot_coeff : i_lin_coeff;
        w_mul  = PROD_W'(w_opnd * w_coef);
    end

    // Floor on negative values, then clip to the pose range
    always_comb begin
        w_qr   = {1'b0, r_q} + (PROD_W+1)'(r_sgn[r_axis] & r_fnz);
        w_lim  = r_sgn[r_axis] ? POSE_NEG_MAG : POSE_POS_MAG;
        w_smag = (w_qr > (PROD_W+1)'(w_lim)) ? w_lim : w_qr[POSE_W-1:0];
        w_rlim = r_rsgn2 ? POSE_NEG_MAG : POSE_POS_MAG;
        w_rmag = (r_rprod > PROD_W'(w_rlim)) ? w_rlim : r_rprod[POSE_W-1:0];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == MG_IDLE) && i_start) begin
            r_sum[AX_X]       <= w_ext[0] + w_ext[1] + w_ext[2] + w_ext[3];
            r_sum[AX_Y]       <= w_ext[1] + w_ext[3] - w_ext[0] - w_ext[2];
            r_sum[AX_HEADING] <= w_ext[0] + w_ext[3] - w_ext[1] - w_ext[2];
        end
        if (r_state == MG_MAG) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_sgn[k] <= r_sum[k][SUM_W-1];
                r_mag[k] <= r_sum[k][SUM_W-1] ? MAG_W'(-r_sum[k]) : MAG_W'(r_sum[k]);
            end
        end
        if (r_state == MG_LO) begin
            r_prod <= w_mul;
        end
        if (r_state == MG_HI) begin
            r_plo  <= r_prod;
            r_prod <= w_mul;
        end
        if (r_state == MG_ADD) begin
            r_q   <= r_prod + {{COEF_W{1'b0}}, r_plo[PROD_W-1:COEF_W]};
            r_fnz <= |r_plo[COEF_W-1:0];
        end
        if (r_state == MG_FIN) begin
            r_res[r_axis] <= r_sgn[r_axis] ? $signed(-w_smag) : $signed(w_smag);
            r_rmag        <= w_smag;
            r_rsgn        <= r_sgn[r_axis];
            r_rax         <= r_axis;
        end
        // Rate side pipeline, overlapped with the next axis
        if (r_rv1) begin
            r_rprod <= PROD_W'(r_rmag * i_rate_hz);
            r_rsgn2 <= r_rsgn;
            r_rax2  <= r_rax;
        end
        if (r_rv2) begin
            r_rate[r_rax2] <= r_rsgn2 ? $signed(-w_rmag) : $signed(w_rmag);
        end
    end

    assign o_pose = r_res;
    assign o_rate = r_rate;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== sv/mecanum_wheel_odometry_unit.sv =====
// Top level of the mecanum wheel odometry unit: handshakes, configuration,
// sequencer and output register. Depends on mwo_pkg, mwo_lane and mwo_merge.
`default_nettype none

// An encoder sample transaction runs through the lane sample, multiply and
// accumulate steps and then the merging stage; its result is loaded into
// the output register once the previous result has left, and the next
// transaction is then taken. A clear transaction goes straight to the
// output register. The shared 32x32 multiplier in the merging stage forms
// each of the three pose deltas from two partial products; the four wheel
// lanes work in parallel and the rate multiplies overlap the next axis. The
// unit accepts a new transaction while its last result still waits.
module mecanum_wheel_odometry_unit
    import mwo_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int ANGLE_BITS = 56
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_operation,
    input  wire logic [COUNT_BITS-1:0]      i_count_one,
    input  wire logic [COUNT_BITS-1:0]      i_count_two,
    input  wire logic [COUNT_BITS-1:0]      i_count_three,
    input  wire logic [COUNT_BITS-1:0]      i_count_four,
    // Output channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output t_pose                           o_delta_x,
    output t_pose                           o_delta_y,
    output t_pose                           o_delta_heading,
    output t_pose                           o_rate_x,
    output t_pose                           o_rate_y,
    output t_pose                           o_rate_heading,
    output logic signed [ANGLE_BITS-1:0]    o_angle_one,
    output logic signed [ANGLE_BITS-1:0]    o_angle_two,
    output logic signed [ANGLE_BITS-1:0]    o_angle_three,
    output logic signed [ANGLE_BITS-1:0]    o_angle_four,
    // Configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]           i_cfg_data
);

    t_coef                          r_rad_per_tick;
    t_coef                          r_lin_coeff;
    t_coef                          r_rot_coeff;
    t_rate                          r_rate_hz;

    t_state                         r_state;
    t_state                         n_state;
    t_lane_ctl                      w_lane_ctl;
    logic                           w_start;
    logic                           w_load;
    logic                           w_free;
    logic                           w_in_acc;
    logic                           r_seen;
    logic                           r_clear;

    logic [COUNT_BITS-1:0]          w_count [NUM_WHEELS];
    t_inc                           w_inc   [NUM_WHEELS];
    logic signed [ANGLE_BITS-1:0]   w_angle [NUM_WHEELS];
    t_pose                          w_pose  [NUM_AXES];
    t_pose                          w_rate  [NUM_AXES];
    logic                           w_mg_done;

    logic                           r_out_valid;
    t_pose                          r_pose_out [NUM_AXES];
    t_pose                          r_rate_out [NUM_AXES];
    logic signed [ANGLE_BITS-1:0]   r_angle_out [NUM_WHEELS];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_per_tick <= RAD_PER_TICK_RST;
            r_lin_coeff    <= LIN_COEFF_RST;
            r_rot_coeff    <= ROT_COEFF_RST;
            r_rate_hz      <= RATE_HZ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAD_PER_TICK: r_rad_per_tick <= i_cfg_data[COEF_W-1:0];
                CFG_LIN_COEFF:    r_lin_coeff    <= i_cfg_data[COEF_W-1:0];
                CFG_ROT_COEFF:    r_rot_coeff    <= i_cfg_data[COEF_W-1:0];
                CFG_RATE_HZ:      r_rate_hz      <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_free     = !r_out_valid || !i_out_stall;

    // Sequencer: next state and strobes
    always_comb begin
        n_state    = r_state;
        w_lane_ctl = '0;
        w_start    = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == OP_CLEAR) begin
                        w_lane_ctl.clear = 1'b1;
                        n_state          = ST_DONE;
                    end else begin
                        w_lane_ctl.sample = 1'b1;
                        n_state           = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                w_lane_ctl.mult = 1'b1;
                n_state         = ST_ACC;
            end
            ST_ACC: begin
                w_lane_ctl.accum = 1'b1;
                n_state          = ST_START;
            end
            ST_START: begin
                w_start = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_mg_done) begin
                    if (w_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seen  <= 1'b0;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_clear <= (i_operation == OP_CLEAR);
                if (i_operation == OP_SAMPLE) begin
                    r_seen <= 1'b1;
                end
            end
        end
    end

    // Wheel lanes
    assign w_count[0] = i_count_one;
    assign w_count[1] = i_count_two;
    assign w_count[2] = i_count_three;
    assign w_count[3] = i_count_four;

    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        mwo_lane #(
            .COUNT_BITS (COUNT_BITS),
            .ANGLE_BITS (ANGLE_BITS)
        ) u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_lane_ctl),
            .i_first_sample (!r_seen),
            .i_count        (w_count[g]),
            .i_rad_per_tick (r_rad_per_tick),
            .o_inc          (w_inc[g]),
            .o_angle        (w_angle[g])
        );
    end

    mwo_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_inc       (w_inc),
        .i_lin_coeff (r_lin_coeff),
        .i_rot_coeff (r_rot_coeff),
        .i_rate_hz   (r_rate_hz),
        .o_pose      (w_pose),
        .o_rate      (w_rate),
        .o_done      (w_mg_done)
    );

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_pose_out[k] <= r_clear ? '0 : w_pose[k];
                r_rate_out[k] <= r_clear ? '0 : w_rate[k];
            end
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_angle_out[k] <= w_angle[k];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_delta_x       = r_pose_out[AX_X];
    assign o_delta_y       = r_pose_out[AX_Y];
    assign o_delta_heading = r_pose_out[AX_HEADING];
    assign o_rate_x        = r_rate_out[AX_X];
    assign o_rate_y        = r_rate_out[AX_Y];
    assign o_rate_heading  = r_rate_out[AX_HEADING];
    assign o_angle_one     = r_angle_out[0];
    assign o_angle_two     = r_angle_out[1];
    assign o_angle_three   = r_angle_out[2];
    assign o_angle_four    = r_angle_out[3];

    // Merge completion only arrives while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mg_done |-> (r_state == ST_WAIT))
        else $error("merge completion outside the wait state");

    // At most one lane strobe per cycle
    a_lane_ctl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_lane_ctl))
        else $error("more than one lane strobe active");

    // A clear transaction zeroes every wheel angle
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_operation == OP_CLEAR)) |=>
        ((w_angle[0] == '0) && (w_angle[1] == '0) &&
         (w_angle[2] == '0) && (w_angle[3] == '0)))
        else $error("wheel angles not cleared");

    // Once a sample has been seen the flag stays set
    a_seen_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("first-sample flag dropped");

endmodule

`default_nettype wire
